@@ rtl/cerg_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cerg_pkg
// Shared constants and types of the camera eye-ray generator.
// ---------------------------------------------------------------------------
package cerg_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int DIR_FRAC_BITS_DEF = 14;

  // Normalized magnitude: largest part has its top bit at bit 29.
  localparam int MAG_W  = 30;
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int POS_W  = 32;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int BASIS_W    = 48;

  localparam logic [2:0] REG_RIGHT = 3'd0;
  localparam logic [2:0] REG_UP    = 3'd1;
  localparam logic [2:0] REG_FRONT = 3'd2;
  localparam logic [2:0] REG_PIN_X = 3'd3;
  localparam logic [2:0] REG_PIN_Y = 3'd4;
  localparam logic [2:0] REG_PIN_Z = 3'd5;

  localparam logic [BASIS_W-1:0] RIGHT_RST = 48'd2048;
  localparam logic [BASIS_W-1:0] UP_RST    = 48'd134217728;
  localparam logic [BASIS_W-1:0] FRONT_RST = 48'd263882790666240;

  typedef struct packed {
    logic [2:0][POS_W-1:0] origin;
    logic [2:0]            neg;
    logic                  degen;
  } side_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    side_t                 side;
  } carry_t;

endpackage
`default_nettype wire

@@ rtl/cerg_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cerg_front
// Offset vector from the basis, ray origin with rounding and saturation,
// and per-part magnitude and sign. Three register stages.
// ---------------------------------------------------------------------------
module cerg_front #(
  parameter int COORD_BITS = cerg_pkg::COORD_BITS_DEF,
  localparam int MW = COORD_BITS + 17
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  en,
  input  wire                                  in_valid,
  input  wire [COORD_BITS-1:0]                 u,
  input  wire [COORD_BITS-1:0]                 v,
  input  wire [cerg_pkg::BASIS_W-1:0]          right,
  input  wire [cerg_pkg::BASIS_W-1:0]          up,
  input  wire [cerg_pkg::BASIS_W-1:0]          front,
  input  wire [2:0][cerg_pkg::POS_W-1:0]       pin,
  output logic                                 out_valid,
  output logic [2:0][MW-1:0]                   mag,
  output cerg_pkg::side_t                      side
);

  localparam int CB = COORD_BITS;
  localparam int RW = CB + 18;
  localparam int K  = CB - 4;
  localparam int DW = CB + 30;

  logic signed [CB+1:0] su, sv;
  assign su = $signed({1'b0, u, 1'b0}) - $signed({2'b01, {CB{1'b0}}});
  assign sv = $signed({1'b0, v, 1'b0}) - $signed({2'b01, {CB{1'b0}}});

  logic                        v1, v2;
  logic signed [2:0][RW-1:0]   pf, pr, pu;
  logic signed [2:0][RW-1:0]   rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pf[i] <= RW'($signed({front[16*i +: 16], {CB{1'b0}}}));
        pr[i] <= RW'($signed(right[16*i +: 16]) * su);
        pu[i] <= RW'($signed(up[16*i +: 16]) * sv);
      end
    end
  end

  // Stage 2: offset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rel[i] <= pf[i] - pr[i] - pu[i];
      end
    end
  end

  // Stage 3: origin, magnitude, sign
  logic signed [2:0][DW-1:0] dsum;
  logic signed [2:0][33:0]   ofl;
  logic [2:0][RW-1:0]        absr;
  logic [2:0][cerg_pkg::POS_W-1:0] osat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i] = $signed({{(DW-cerg_pkg::POS_W-K){pin[i][cerg_pkg::POS_W-1]}}, pin[i],
                         {K{1'b0}}})
              - DW'($signed(rel[i])) + $signed(DW'({1'b1, {(K-1){1'b0}}}));
      ofl[i]  = dsum[i][DW-1:K];
      if (ofl[i][33:31] == 3'b000 || ofl[i][33:31] == 3'b111) begin
        osat[i] = ofl[i][31:0];
      end else if (ofl[i][33]) begin
        osat[i] = 32'h8000_0000;
      end else begin
        osat[i] = 32'h7FFF_FFFF;
      end
      absr[i] = rel[i][RW-1] ? RW'(-rel[i]) : RW'(rel[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]         <= absr[i][MW-1:0];
        side.origin[i] <= osat[i];
        side.neg[i]    <= rel[i][RW-1];
      end
      side.degen <= (rel[0] == '0) && (rel[1] == '0) && (rel[2] == '0);
    end
  end

endmodule
`default_nettype wire

@@ rtl/cerg_norm.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cerg_norm
// Left-justify the three magnitudes by the leading one of their OR, one
// shift step per stage, then square and sum.
// ---------------------------------------------------------------------------
module cerg_norm #(
  parameter int COORD_BITS = cerg_pkg::COORD_BITS_DEF,
  localparam int MW = COORD_BITS + 17
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  wire [2:0][MW-1:0]              mag,
  input  cerg_pkg::side_t                side,
  output logic                           out_valid,
  output logic [cerg_pkg::SUM_W-1:0]     sum,
  output cerg_pkg::carry_t               carry
);

  localparam int NW    = (MW > cerg_pkg::MAG_W) ? MW : cerg_pkg::MAG_W;
  localparam int NSTEP = $clog2(NW);

  logic [2:0][NW-1:0] m   [NSTEP+1];
  cerg_pkg::side_t    sd  [NSTEP+1];
  logic [NSTEP:0]     vld;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[0][i] = NW'(mag[i]);
    end
    sd[0]  = side;
    vld[0] = in_valid;
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int S = 1 << (NSTEP - 1 - j);
    logic [NW-1:0] orv;
    logic          sh;
    assign orv = m[j][0] | m[j][1] | m[j][2];
    assign sh  = (orv[NW-1 -: S] == '0);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          m[j+1][i] <= sh ? (m[j][i] << S) : m[j][i];
        end
        sd[j+1] <= sd[j];
      end
    end
  end

  logic                          vq;
  logic [2:0][2*cerg_pkg::MAG_W-1:0] sq;
  cerg_pkg::carry_t              cq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vq        <= vld[NSTEP];
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cq.mag[i] <= m[NSTEP][i][NW-1 -: cerg_pkg::MAG_W];
        sq[i]     <= m[NSTEP][i][NW-1 -: cerg_pkg::MAG_W] *
                     m[NSTEP][i][NW-1 -: cerg_pkg::MAG_W];
      end
      cq.side <= sd[NSTEP];
      sum     <= cerg_pkg::SUM_W'(sq[0]) + cerg_pkg::SUM_W'(sq[1])
               + cerg_pkg::SUM_W'(sq[2]);
      carry   <= cq;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cerg_isqrt.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cerg_isqrt
// Pipelined integer square root, floor, one result bit per stage.
// ---------------------------------------------------------------------------
module cerg_isqrt (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  wire [cerg_pkg::SUM_W-1:0]      sum,
  input  cerg_pkg::carry_t               carry_in,
  output logic                           out_valid,
  output logic [cerg_pkg::ROOT_W-1:0]    root,
  output cerg_pkg::carry_t               carry_out
);

  localparam int NS = cerg_pkg::ROOT_W;

  logic [cerg_pkg::SUM_W-1:0]  n    [NS+1];
  logic [cerg_pkg::REM_W-1:0]  rm   [NS+1];
  logic [cerg_pkg::ROOT_W-1:0] rt   [NS+1];
  cerg_pkg::carry_t            cr   [NS+1];
  logic [NS:0]                 vld;

  always_comb begin
    n[0]   = sum;
    rm[0]  = '0;
    rt[0]  = '0;
    cr[0]  = carry_in;
    vld[0] = in_valid;
  end

  for (genvar t = 0; t < NS; t++) begin : g_bit
    logic [cerg_pkg::REM_W+1:0] rem4, trial;
    logic                       ge;
    assign rem4  = {rm[t], n[t][2*(NS-1-t)+1 -: 2]};
    assign trial = {2'b00, rt[t], 2'b01};
    assign ge    = (rem4 >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t+1] <= 1'b0;
      end else if (en) begin
        vld[t+1] <= vld[t];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n[t+1]  <= n[t];
        cr[t+1] <= cr[t];
        if (ge) begin
          rm[t+1] <= cerg_pkg::REM_W'(rem4 - trial);
          rt[t+1] <= {rt[t][cerg_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rm[t+1] <= rem4[cerg_pkg::REM_W-1:0];
          rt[t+1] <= {rt[t][cerg_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = rt[NS];
  assign carry_out = cr[NS];

endmodule
`default_nettype wire

@@ rtl/cerg_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cerg_div
// Three lanes of pipelined restoring division, one quotient bit per stage,
// giving the rounded unit direction parts.
// ---------------------------------------------------------------------------
module cerg_div #(
  parameter int DIR_FRAC_BITS = cerg_pkg::DIR_FRAC_BITS_DEF,
  localparam int DW = DIR_FRAC_BITS + 2
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            en,
  input  wire                            in_valid,
  input  wire [cerg_pkg::ROOT_W-1:0]     root,
  input  cerg_pkg::carry_t               carry,
  output logic                           out_valid,
  output logic [2:0][DW-1:0]             dir,
  output cerg_pkg::side_t                side
);

  localparam int F   = DIR_FRAC_BITS;
  localparam int QW  = F + 1;
  localparam int NLW = cerg_pkg::MAG_W + F + 1;
  localparam int RW  = cerg_pkg::ROOT_W;

  logic [2:0][RW-1:0]  rm  [QW+1];
  logic [2:0][QW-1:0]  lo  [QW+1];
  logic [2:0][QW-1:0]  q   [QW+1];
  logic [RW-1:0]       dv  [QW+1];
  cerg_pkg::side_t     sd  [QW+1];
  logic [QW:0]         vld;

  logic [2:0][NLW-1:0] num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NLW'({carry.mag[i], {F{1'b0}}}) + NLW'(root >> 1);
    end
  end

  // Stage 0: dividend set-up; the high part is already below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rm[0][i] <= RW'(num[i][NLW-1:QW]);
        lo[0][i] <= num[i][QW-1:0];
        q[0][i]  <= '0;
      end
      dv[0] <= root;
      sd[0] <= carry.side;
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_bit
    logic [2:0][RW:0] r2;
    logic [2:0]       ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {rm[t][i], lo[t][i][QW-1]};
        ge[i] = (r2[i] >= {1'b0, dv[t]});
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[t+1] <= 1'b0;
      end else if (en) begin
        vld[t+1] <= vld[t];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rm[t+1][i] <= ge[i] ? RW'(r2[i] - {1'b0, dv[t]}) : RW'(r2[i]);
          lo[t+1][i] <= {lo[t][i][QW-2:0], 1'b0};
          q[t+1][i]  <= {q[t][i][QW-2:0], ge[i]};
        end
        dv[t+1] <= dv[t];
        sd[t+1] <= sd[t];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = sd[QW].neg[i] ? DW'(-{1'b0, q[QW][i]}) : DW'({1'b0, q[QW][i]});
    end
  end

  assign out_valid = vld[QW];
  assign side      = sd[QW];

endmodule
`default_nettype wire

@@ rtl/camera_eye_ray_generation.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// camera_eye_ray_generation
// Pinhole camera eye-ray generator: (u,v) in, ray origin and unit direction
// out, fixed point throughout.
//
// Input stream s_*: one item per pixel sample, (u,v). Output stream m_*: one
// item per input, origin, direction and the degenerate flag in tuser.
// Throughput is one item per cycle unless a stalled receiver holds the
// output. Each item passes through the offset stages, the normalize shifts,
// the square-and-sum stages, the bit-per-stage square root and divider, and
// the output register.
// The whole pipeline advances together; a stalled receiver holds the output
// register and s_tready drops until the result is taken, so nothing is lost
// or repeated. Reset clears all valid bits and restores the basis and
// pinhole registers to their defaults. Write registers on the APB port only
// while the pipeline is empty.
// ---------------------------------------------------------------------------
module camera_eye_ray_generation #(
  parameter int COORD_BITS    = cerg_pkg::COORD_BITS_DEF,
  parameter int DIR_FRAC_BITS = cerg_pkg::DIR_FRAC_BITS_DEF,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int DW    = DIR_FRAC_BITS + 2,
  localparam int OUT_W = ((3 * cerg_pkg::POS_W + 3 * DW + 7) / 8) * 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [IN_W-1:0]                   s_tdata,  // coord_u, coord_v
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic [OUT_W-1:0]                 m_tdata,
  output logic                             m_tuser,  // degenerate
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [cerg_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire [cerg_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cerg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int MW = COORD_BITS + 17;

  logic [cerg_pkg::BASIS_W-1:0]    right, up, front;
  logic [2:0][cerg_pkg::POS_W-1:0] pin;
  logic [2:0]                      idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      right <= cerg_pkg::RIGHT_RST;
      up    <= cerg_pkg::UP_RST;
      front <= cerg_pkg::FRONT_RST;
      pin   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        cerg_pkg::REG_RIGHT: right  <= pwdata[cerg_pkg::BASIS_W-1:0];
        cerg_pkg::REG_UP:    up     <= pwdata[cerg_pkg::BASIS_W-1:0];
        cerg_pkg::REG_FRONT: front  <= pwdata[cerg_pkg::BASIS_W-1:0];
        cerg_pkg::REG_PIN_X: pin[0] <= pwdata[cerg_pkg::POS_W-1:0];
        cerg_pkg::REG_PIN_Y: pin[1] <= pwdata[cerg_pkg::POS_W-1:0];
        cerg_pkg::REG_PIN_Z: pin[2] <= pwdata[cerg_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cerg_pkg::REG_RIGHT: prdata = 64'(right);
      cerg_pkg::REG_UP:    prdata = 64'(up);
      cerg_pkg::REG_FRONT: prdata = 64'(front);
      cerg_pkg::REG_PIN_X: prdata = 64'(pin[0]);
      cerg_pkg::REG_PIN_Y: prdata = 64'(pin[1]);
      cerg_pkg::REG_PIN_Z: prdata = 64'(pin[2]);
      default:             prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless the output item is held
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                  f_valid;
  logic [2:0][MW-1:0]    f_mag;
  cerg_pkg::side_t       f_side;

  cerg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .u         (s_tdata[COORD_BITS-1:0]),
    .v         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .right     (right),
    .up        (up),
    .front     (front),
    .pin       (pin),
    .out_valid (f_valid),
    .mag       (f_mag),
    .side      (f_side)
  );

  logic                          n_valid;
  logic [cerg_pkg::SUM_W-1:0]    n_sum;
  cerg_pkg::carry_t              n_carry;

  cerg_norm #(.COORD_BITS(COORD_BITS)) u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .mag       (f_mag),
    .side      (f_side),
    .out_valid (n_valid),
    .sum       (n_sum),
    .carry     (n_carry)
  );

  logic                          q_valid;
  logic [cerg_pkg::ROOT_W-1:0]   q_root;
  cerg_pkg::carry_t              q_carry;

  cerg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_valid),
    .sum       (n_sum),
    .carry_in  (n_carry),
    .out_valid (q_valid),
    .root      (q_root),
    .carry_out (q_carry)
  );

  logic                 d_valid;
  logic [2:0][DW-1:0]   d_dir;
  cerg_pkg::side_t      d_side;

  cerg_div #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .root      (q_root),
    .carry     (q_carry),
    .out_valid (d_valid),
    .dir       (d_dir),
    .side      (d_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_valid;
    end
  end

  // Zero the direction of a degenerate offset
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({(d_side.degen ? '0 : d_dir), d_side.origin});
      m_tuser <= d_side.degen;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the camera eye-ray generator. A short stimulus
// table covers the image corners, the plane center, a zero offset and origin
// saturation. Random rays follow under several basis and pinhole settings.
// Every result item is compared field by field against a local ray model or a fixed expected value.
// Both stream sides idle in random bursts.
// ---------------------------------------------------------------------------
module tb_top;
  import cerg_pkg::*;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int         LIMIT       = 400000;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][15:0] dir;
    logic             degen;
  } ray_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // coord_u, coord_v
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;        // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  logic         m_tuser;        // degenerate
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  camera_eye_ray_generation i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the configuration
  logic [47:0] basis_right, basis_up, basis_front;
  logic [2:0][31:0] pinhole;

  ray_t expected_rays[$];
  int   errors = 0;
  int   rays_seen = 0;
  int   degen_seen = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  int   hold_rx = 0;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic ray_t trace_ray(logic [15:0] u, logic [15:0] v);
    longint su, sv, d, o;
    longint rel[3];
    longint unsigned mag[3];
    longint unsigned maxm, sum, r, q;
    int pos;
    ray_t res;
    su = longint'(u) * 2 - 65536;
    sv = longint'(v) * 2 - 65536;
    maxm = 0;
    sum = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = longint'($signed(basis_front[16*i +: 16])) * 65536
             - longint'($signed(basis_right[16*i +: 16])) * su
             - longint'($signed(basis_up[16*i +: 16])) * sv;
      d = longint'($signed(pinhole[i])) * 4096 - rel[i];
      o = (d + 2048) >>> 12;
      if (o > 64'sd2147483647) o = 64'sd2147483647;
      if (o < -64'sd2147483648) o = -64'sd2147483648;
      res.org[i] = o[31:0];
      mag[i] = rel[i] < 0 ? longint'(-rel[i]) : longint'(rel[i]);
      if (mag[i] > maxm) maxm = mag[i];
    end
    if (maxm == 0) begin
      res.degen = 1'b1;
      return res;
    end
    pos = 0;
    while ((maxm >> pos) > 1) pos++;
    for (int i = 0; i < 3; i++) begin
      if (pos > 29) mag[i] >>= (pos - 29);
      else mag[i] <<= (29 - pos);
      sum += mag[i] * mag[i];
    end
    r = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 14) + (r >> 1)) / r;
      res.dir[i] = rel[i] < 0 ? 16'(-q) : 16'(q);
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on ray %0d: %s got %0h want %0h", rays_seen, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    ray_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rays.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        want = expected_rays.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[32*i +: 32] !== want.org[i]) report($sformatf("origin[%0d]", i),
            m_tdata[32*i +: 32], want.org[i]);
          if (m_tdata[96+16*i +: 16] !== want.dir[i]) report($sformatf("dir[%0d]", i),
            m_tdata[96+16*i +: 16], want.dir[i]);
        end
        if (m_tuser !== want.degen) report("degenerate", m_tuser, want.degen);
        if (want.degen) degen_seen++;
      end
      rays_seen++;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      hold_rx <= $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("camera_eye_ray_generation test failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RIGHT: basis_right = value[47:0];
      REG_UP:    basis_up = value[47:0];
      REG_FRONT: basis_front = value[47:0];
      REG_PIN_X: pinhole[0] = value[31:0];
      REG_PIN_Y: pinhole[1] = value[31:0];
      REG_PIN_Z: pinhole[2] = value[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (expected_rays.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_ray(logic [15:0] u, logic [15:0] v, bit typed, ray_t want);
    s_tvalid <= 1'b1;
    s_tdata <= {v, u};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_rays.push_back(typed ? want : trace_ray(u, v));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_lane();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_pin();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 32'h100000)) - 32'h80000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    reg_write(REG_RIGHT, {16'($urandom), pick_lane(), pick_lane(), pick_lane()});
    reg_write(REG_UP, {16'($urandom), pick_lane(), pick_lane(), pick_lane()});
    reg_write(REG_FRONT, {16'($urandom), pick_lane(), pick_lane(), pick_lane()});
    reg_write(REG_PIN_X, {$urandom, pick_pin()});
    reg_write(REG_PIN_Y, {$urandom, pick_pin()});
    reg_write(REG_PIN_Z, {$urandom, pick_pin()});
  endtask

  logic [15:0] tab_u[9] = '{16'h8000, 16'h0000, 16'hffff, 16'h0000, 16'hffff,
                            16'h0001, 16'h8000, 16'h0000, 16'h7fff};
  logic [15:0] tab_v[9] = '{16'h8000, 16'h0000, 16'hffff, 16'hffff, 16'h0000,
                            16'h0001, 16'h0000, 16'h8000, 16'h8001};

  initial begin
    ray_t want;
    logic [15:0] u, v;
    basis_right = RIGHT_RST;
    basis_up = UP_RST;
    basis_front = FRONT_RST;
    pinhole = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset basis: center looks down -z from one unit behind the plane
    for (int i = 0; i < 9; i++) begin
      want = '0;
      want.org[2] = 32'd65536;
      want.dir[2] = -16'sd16384;
      send_ray(tab_u[i], tab_v[i], i == 0, want);
    end
    s_tvalid <= 1'b0;
    drain();

    // zero offset at the center: origin is the pinhole, flag raised
    reg_write(REG_FRONT, 64'hdead_0000_0000_0000);
    reg_write(REG_RIGHT, {16'hbeef, pick_lane(), pick_lane(), pick_lane()});
    reg_write(REG_PIN_X, 64'h1234_5678_0001_8000);
    reg_write(REG_PIN_Y, {$urandom, $urandom});
    reg_write(REG_PIN_Z, 64'h8000_0000);
    reg_write(REG_SPARE_A, {$urandom, $urandom});
    reg_write(REG_SPARE_B, {$urandom, $urandom});
    want = '0;
    want.org = pinhole;
    want.degen = 1'b1;
    send_ray(16'h8000, 16'h8000, 1'b1, want);
    send_ray(16'h0000, 16'h8000, 1'b0, want);
    s_tvalid <= 1'b0;
    drain();
    reg_write(REG_RIGHT, 64'h0);
    reg_write(REG_UP, 64'h0);
    send_ray(16'h0000, 16'hffff, 1'b1, want);
    s_tvalid <= 1'b0;
    drain();

    // extreme lanes push the origin into saturation both ways
    reg_write(REG_RIGHT, 64'h8000_8000_8000);
    reg_write(REG_UP, 64'h8000_8000_8000);
    reg_write(REG_FRONT, 64'h8000_8000_8000);
    reg_write(REG_PIN_X, 64'h7fffffff);
    reg_write(REG_PIN_Y, 64'h80000000);
    reg_write(REG_PIN_Z, 64'h7fffffff);
    for (int i = 0; i < 5; i++) send_ray(tab_u[i], tab_v[i], 1'b0, want);
    s_tvalid <= 1'b0;
    drain();
    reg_write(REG_RIGHT, 64'h7fff_7fff_7fff);
    reg_write(REG_UP, 64'h7fff_8000_7fff);
    reg_write(REG_FRONT, 64'h7fff_7fff_7fff);
    reg_write(REG_PIN_X, 64'h80000000);
    reg_write(REG_PIN_Z, 64'h80000000);
    for (int i = 0; i < 5; i++) send_ray(tab_u[i], tab_v[i], 1'b0, want);
    s_tvalid <= 1'b0;
    drain();

    // random rays under a fresh setting per phase; the last phase runs flat out
    for (int phase = 0; phase < 6; phase++) begin
      random_config();
      if (phase == 5) quiet = 1'b1;
      for (int n = 0; n < 125; n++) begin
        case ($urandom_range(0, 9))
          0: begin u = 16'h8000; v = 16'h8000; end
          1: begin u = $urandom_range(0, 1) ? 16'hffff : 16'h0000; v = 16'($urandom); end
          default: begin u = 16'($urandom); v = 16'($urandom); end
        endcase
        send_ray(u, v, 1'b0, want);
        if (phase == 2 && n == 60) begin
          s_tvalid <= 1'b0;
          while (expected_rays.size() != 0) @(posedge clk);
        end
      end
      s_tvalid <= 1'b0;
      drain();
    end

    repeat (100) @(posedge clk);
    $display("checked %0d rays, %0d degenerate, over corner, center, saturation", rays_seen,
      degen_seen);
    $display("and six random basis and pinhole settings with stalls on both sides");
    if (errors == 0) begin
      $display("camera_eye_ray_generation test passed");
    end else begin
      $display("camera_eye_ray_generation test failed");
    end
    $finish;
  end

endmodule
